FILE: design/igsf_pkg.sv
// Package for the IGMP snooping group filter: table size, protocol codes,
// register indexes, payload structs and controller/datapath handshake types.
// No dependencies.
package igsf_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [15:0] ETHER_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_IGMP     = 8'h02;
  localparam logic [7:0]  IGMP_V2_REPORT = 8'h16;
  localparam logic [7:0]  IGMP_V2_LEAVE  = 8'h17;
  localparam logic [7:0]  IGMP_V3_REPORT = 8'h22;
  localparam logic [7:0]  REC_TO_INCLUDE = 8'h03;
  localparam logic [7:0]  REC_TO_EXCLUDE = 8'h04;
  localparam logic [7:0]  MAC_MCAST      = 8'h01;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_LAN_PORT = 2'd1;
  localparam logic [1:0] REG_WAN_PORT = 2'd2;

  typedef struct packed {
    logic [3:0]  ingress_port;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] ip_dest;
    logic [7:0]  dest_mac_first;
    logic [7:0]  igmp_type;
    logic [31:0] igmp_group;
    logic [7:0]  record_kind;
    logic [31:0] record_group;
  } in_item_t;

  typedef struct packed {
    logic forward_to_lan;
    logic group_added;
    logic group_removed;
    logic add_dropped;
  } out_item_t;

  typedef struct packed {
    logic capture;       // load the input item
    logic scan_start;    // reset the scan and latch the search key
    logic scan_key_fwd;  // with scan_start: key is ip_dest, else the group
    logic scan_run;      // step the table scan
    logic apply;         // perform the add or remove
    logic fwd_latch;     // record the forwarding decision
    logic emit;          // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic need_upd;
    logic need_fwd;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/igsf_ctrl.sv
// Controller of the IGMP snooping group filter: sequences capture, table
// scans, the table update and result hand-off. Depends on igsf_pkg.
module igsf_ctrl import igsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_PICK      = 7'b0000010,
    ST_SCAN_UPD  = 7'b0000100,
    ST_APPLY     = 7'b0001000,
    ST_START_FWD = 7'b0010000,
    ST_SCAN_FWD  = 7'b0100000,
    ST_FINISH    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PICK;
        end
      end
      ST_PICK: begin
        if (status.need_upd) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN_UPD;
        end else if (status.need_fwd) begin
          cmd.scan_start   = 1'b1;
          cmd.scan_key_fwd = 1'b1;
          state_nxt        = ST_SCAN_FWD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN_UPD: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = status.need_fwd ? ST_START_FWD : ST_FINISH;
      end
      ST_START_FWD: begin
        cmd.scan_start   = 1'b1;
        cmd.scan_key_fwd = 1'b1;
        state_nxt        = ST_SCAN_FWD;
      end
      ST_SCAN_FWD: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          cmd.fwd_latch = 1'b1;
          state_nxt     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/igsf_dpath.sv
// Datapath of the IGMP snooping group filter: item register, header decode,
// group table memory with valid bits, scan unit and result register.
// Depends on igsf_pkg.
module igsf_dpath import igsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_enable,
  input  logic [3:0] cfg_lan_port,
  input  logic [3:0] cfg_wan_port,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_data
);

  in_item_t item_r;

  logic        lan_igmp;
  logic        is_v3;
  logic        do_add;
  logic        do_rem;
  logic        do_fwd;
  logic [31:0] upd_key;

  logic [31:0] tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  logic [31:0]      key_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [31:0]      rd_data_r;
  logic             found_r;
  logic [IDX_W-1:0] match_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             issue;
  logic             mem_we;

  logic      fwd_r, added_r, removed_r, dropped_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  // Header decode on the captured item.
  assign lan_igmp = cfg_enable && (item_r.ingress_port == cfg_lan_port) &&
                    (item_r.ether_type == ETHER_IPV4) &&
                    (item_r.ip_protocol == PROTO_IGMP);
  assign is_v3    = (item_r.igmp_type == IGMP_V3_REPORT);
  assign do_add   = lan_igmp && ((item_r.igmp_type == IGMP_V2_REPORT) ||
                    (is_v3 && (item_r.record_kind == REC_TO_EXCLUDE)));
  assign do_rem   = lan_igmp && ((item_r.igmp_type == IGMP_V2_LEAVE) ||
                    (is_v3 && (item_r.record_kind == REC_TO_INCLUDE)));
  assign do_fwd   = cfg_enable && (item_r.ingress_port == cfg_wan_port) &&
                    (item_r.dest_mac_first == MAC_MCAST);
  assign upd_key  = is_v3 ? item_r.record_group : item_r.igmp_group;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // Scan: one table read issued per cycle, compared in the cycle after.
  assign issue  = cmd.scan_run && (cnt_r != CNT_W'(TABLE_DEPTH));
  assign mem_we = cmd.apply && do_add && !found_r && free_found_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[free_idx_r] <= key_r;
    end
    if (issue) begin
      rd_data_r <= tbl_mem[cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      key_r <= cmd.scan_key_fwd ? item_r.ip_dest : upd_key;
    end
    if (issue) begin
      rd_idx_r <= cnt_r[IDX_W-1:0];
    end
    if (cmd.scan_run && pend_r) begin
      if (valid_r[rd_idx_r] && (rd_data_r == key_r) && !found_r) begin
        match_idx_r <= rd_idx_r;
      end
      if (!valid_r[rd_idx_r] && !free_found_r) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_start) begin
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_run) begin
      pend_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (pend_r && valid_r[rd_idx_r] && (rd_data_r == key_r)) begin
        found_r <= 1'b1;
      end
      if (pend_r && !valid_r[rd_idx_r]) begin
        free_found_r <= 1'b1;
      end
    end
  end

  // Valid bits and result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      fwd_r     <= 1'b0;
      added_r   <= 1'b0;
      removed_r <= 1'b0;
      dropped_r <= 1'b0;
    end else if (cmd.capture) begin
      fwd_r     <= 1'b0;
      added_r   <= 1'b0;
      removed_r <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[free_idx_r] <= 1'b1;
        added_r             <= 1'b1;
      end
      if (cmd.apply && do_add && !found_r && !free_found_r) begin
        dropped_r <= 1'b1;
      end
      if (cmd.apply && do_rem && found_r) begin
        valid_r[match_idx_r] <= 1'b0;
        removed_r            <= 1'b1;
      end
      if (cmd.fwd_latch) begin
        fwd_r <= found_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.forward_to_lan <= fwd_r;
      out_data_r.group_added    <= added_r;
      out_data_r.group_removed  <= removed_r;
      out_data_r.add_dropped    <= dropped_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.need_upd  = do_add || do_rem;
  assign status.need_fwd  = do_fwd;
  assign status.scan_done = (cnt_r == CNT_W'(TABLE_DEPTH)) && !pend_r;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

FILE: design/igmp_snooping_group_filter.sv
// Top level of the IGMP snooping group filter: configuration registers on an
// APB-style port, controller and datapath. Depends on igsf_pkg, igsf_ctrl
// and igsf_dpath.
//
// The block takes one summarized packet header per transfer on the in_
// channel and returns exactly one result transfer on the out_ channel for
// each. While enabled, IGMP packets on the LAN port update a table of
// TABLE_DEPTH subscribed group addresses (v2 report adds, v2 leave removes,
// a v3 report acts on its first record), and packets on the WAN port with a
// multicast destination MAC are flagged for the LAN when their IP destination
// is a valid table entry. The table lives in a single-port memory with one
// valid flip-flop per entry, so every search walks the table one entry per
// cycle through the memory read port. An item that needs no search goes
// straight from capture to its result; a forwarding check scans the table
// once, a table update scans it and then applies the add or remove, and an
// item that does both runs the update before the forwarding scan. One item
// is worked on at a time, but a finished result waits in an output register,
// so the next item is taken while the previous result is still unclaimed.
// After reset the table is empty and no clearing pass is needed. Registers:
// enable at 0x0, lan_port at 0x4, wan_port at 0x8; they should be written
// only while no item is in flight.
module igmp_snooping_group_filter import igsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic       enable_r;
  logic [3:0] lan_port_r;
  logic [3:0] wan_port_r;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The port never inserts wait states; a register is written in the access
  // cycle of a write transfer.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      lan_port_r <= 4'd0;
      wan_port_r <= 4'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENABLE:   enable_r   <= cfg_pwdata[0];
        REG_LAN_PORT: lan_port_r <= cfg_pwdata[3:0];
        REG_WAN_PORT: wan_port_r <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the register value, zero-extended; unused addresses read 0.
  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:   cfg_prdata = {{(CFG_DW-1){1'b0}}, enable_r};
      REG_LAN_PORT: cfg_prdata = {{(CFG_DW-4){1'b0}}, lan_port_r};
      REG_WAN_PORT: cfg_prdata = {{(CFG_DW-4){1'b0}}, wan_port_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // The controller steps through capture, update scan, apply, forwarding
  // scan and result hand-off; the datapath holds all item and table state.
  igsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  igsf_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .cfg_enable   (enable_r),
    .cfg_lan_port (lan_port_r),
    .cfg_wan_port (wan_port_r),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

FILE: design/igsf_checker.sv
// Port-level checker for the IGMP snooping group filter, bound to the top
// level. Depends on igsf_pkg and igmp_snooping_group_filter.
module igsf_checker import igsf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_pready
);

  // A held result must not change until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // An item does at most one of add, remove or dropped add.
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.group_added, out_data.group_removed,
                              out_data.add_dropped}) <= 1)
    else $error("more than one table outcome flagged");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port stalled");

endmodule

bind igmp_snooping_group_filter igsf_checker u_igsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);

FILE: bench/tb.sv
// Self-checking bench for the IGMP snooping group filter: directed and random
// header streams, APB register writes with readback, and a scoreboard fed by
// a shadow model of the group table. Depends on igsf_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import igsf_pkg::*;

  // The receiver's forced hold-off length. The watchdog limit covers that
  // hold-off, the slowest item (forwarding check plus table update), and the
  // sender's longest gap, several times over.
  localparam int RX_HOLD        = 600;
  localparam int WATCHDOG_LIMIT = 8 * (2 * TABLE_DEPTH + 9) + 4 * RX_HOLD;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Shadow of the block's configuration, matching its reset values.
  logic       snoop_on = 1'b0;
  logic [3:0] lan_sel  = 4'd0;
  logic [3:0] wan_sel  = 4'd1;

  // Shadow of the group table. Addresses are only looked at where the live
  // bit is set, just as in the block.
  logic [31:0] grp_addr [TABLE_DEPTH];
  bit          grp_live [TABLE_DEPTH];

  // Group addresses that the random stimulus draws from, so that joins,
  // leaves and forwarding lookups keep hitting the same entries.
  logic [31:0] grp_pool [$];

  // Verdicts predicted at each input transfer, oldest first.
  out_item_t verdicts_due [$];

  int  fail_count   = 0;
  int  stall_cycles = 0;
  logic quiet       = 1'b0;   // no idling on either side while set
  logic hold_req    = 1'b0;   // toggled to ask the receiver for a hold-off

  igmp_snooping_group_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow model of the filter.
  // ---------------------------------------------------------------------

  // Lowest live slot holding the address, or -1 when it is not subscribed.
  function automatic int group_slot(input logic [31:0] addr);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (grp_live[i] && grp_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // A join stores the group in the lowest free slot unless it is already
  // present; with no free slot left the join is dropped and flagged.
  function automatic void group_join(input logic [31:0] addr, inout out_item_t verdict);
    if (group_slot(addr) >= 0) return;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!grp_live[i]) begin
        grp_addr[i] = addr;
        grp_live[i] = 1'b1;
        verdict.group_added = 1'b1;
        return;
      end
    end
    verdict.add_dropped = 1'b1;
  endfunction

  function automatic void group_leave(input logic [31:0] addr, inout out_item_t verdict);
    int slot;
    slot = group_slot(addr);
    if (slot >= 0) begin
      grp_live[slot] = 1'b0;
      verdict.group_removed = 1'b1;
    end
  endfunction

  // Works out the verdict for one header and updates the shadow table. The
  // table update comes first, so with the LAN and WAN ports equal the
  // forwarding lookup already sees the new table.
  function automatic out_item_t filter_verdict(input in_item_t hdr);
    out_item_t verdict;
    verdict = '0;
    if (snoop_on) begin
      if (hdr.ingress_port == lan_sel && hdr.ether_type == ETHER_IPV4 &&
          hdr.ip_protocol == PROTO_IGMP) begin
        case (hdr.igmp_type)
          IGMP_V2_REPORT: group_join(hdr.igmp_group, verdict);
          IGMP_V2_LEAVE:  group_leave(hdr.igmp_group, verdict);
          IGMP_V3_REPORT: begin
            if (hdr.record_kind == REC_TO_INCLUDE) group_leave(hdr.record_group, verdict);
            else if (hdr.record_kind == REC_TO_EXCLUDE) group_join(hdr.record_group, verdict);
          end
          default: ;
        endcase
      end
      // Only the port, the MAC byte and the table decide forwarding; the Ethernet type
      // and IP protocol are not looked at here.
      if (hdr.ingress_port == wan_sel && hdr.dest_mac_first == MAC_MCAST &&
          group_slot(hdr.ip_dest) >= 0) begin
        verdict.forward_to_lan = 1'b1;
      end
    end
    return verdict;
  endfunction

  // ---------------------------------------------------------------------
  // Reporting, checking and the watchdog.
  // ---------------------------------------------------------------------

  task automatic note_fail(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  // Every result transfer is compared with the oldest predicted verdict.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        note_fail($sformatf("unexpected result fwd=%0b add=%0b rem=%0b drop=%0b",
                            out_data.forward_to_lan, out_data.group_added,
                            out_data.group_removed, out_data.add_dropped));
      end else begin
        want = verdicts_due.pop_front();
        if (out_data.forward_to_lan !== want.forward_to_lan ||
            out_data.group_added    !== want.group_added ||
            out_data.group_removed  !== want.group_removed ||
            out_data.add_dropped    !== want.add_dropped) begin
          note_fail({$sformatf("result mismatch: expected fwd=%0b add=%0b rem=%0b drop=%0b",
                               want.forward_to_lan, want.group_added, want.group_removed,
                               want.add_dropped),
                     $sformatf(", got fwd=%0b add=%0b rem=%0b drop=%0b",
                               out_data.forward_to_lan, out_data.group_added,
                               out_data.group_removed, out_data.add_dropped)});
        end
      end
    end
  end

  // The run is abandoned when no transfer happens on either channel for far
  // longer than any correct run could need.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("** igmp_snooping_group_filter: FAILED **");
        $finish;
      end
    end
  end

  // The receiver stalls in about a third of the cycles. A toggle of hold_req
  // makes it hold off while a counter loaded with RX_HOLD runs down, so
  // that the block fills up and has to refuse input.
  always @(posedge clk) begin : receiver
    logic hold_seen;
    int   hold_left;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = RX_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 36);
    end
  end

  initial begin
    receiver.hold_seen = 1'b0;
    receiver.hold_left = 0;
  end

  // ---------------------------------------------------------------------
  // Input channel and register port.
  // ---------------------------------------------------------------------

  // Offers one header after a random idle gap and waits for its transfer.
  // The verdict is predicted at the accepting edge, since the block works on
  // items strictly in order.
  task automatic send_hdr(input in_item_t hdr);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < 36) gap++;
      if ($urandom_range(99) == 0) gap += $urandom_range(300);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= hdr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdicts_due.push_back(filter_verdict(hdr));
  endtask

  // Stops offering input and waits until every predicted verdict has come.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // One APB transfer: a setup cycle, then an access cycle that completes at
  // the edge where pready is high. The bus is parked idle afterwards.
  task automatic cfg_xfer(input logic wr, input logic [1:0] idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_readback(input logic [1:0] idx);
    logic [31:0] rd;
    logic [31:0] want;
    cfg_xfer(1'b0, idx, '0, rd);
    case (idx)
      REG_ENABLE:   want = {31'b0, snoop_on};
      REG_LAN_PORT: want = {28'b0, lan_sel};
      REG_WAN_PORT: want = {28'b0, wan_sel};
      default:      want = '0;
    endcase
    if (rd !== want) begin
      note_fail($sformatf("register %0d reads %h, expected %h", idx, rd, want));
    end
  endtask

  task automatic cfg_set(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    cfg_xfer(1'b1, idx, value, rd);
    case (idx)
      REG_ENABLE:   snoop_on = value[0];
      REG_LAN_PORT: lan_sel  = value[3:0];
      REG_WAN_PORT: wan_sel  = value[3:0];
      default: ;
    endcase
    cfg_readback(idx);
  endtask

  // Registers are only touched once the block has nothing in flight.
  task automatic configure(input logic en, input logic [3:0] lan, input logic [3:0] wan);
    settle();
    cfg_set(REG_ENABLE, {31'b0, en});
    cfg_set(REG_LAN_PORT, {28'b0, lan});
    cfg_set(REG_WAN_PORT, {28'b0, wan});
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------

  function automatic in_item_t mk_hdr(input logic [3:0] port, input logic [15:0] etype,
                                      input logic [7:0] proto, input logic [31:0] dest,
                                      input logic [7:0] mac, input logic [7:0] itype,
                                      input logic [31:0] igrp, input logic [7:0] rkind,
                                      input logic [31:0] rgrp);
    in_item_t hdr;
    hdr.ingress_port   = port;
    hdr.ether_type     = etype;
    hdr.ip_protocol    = proto;
    hdr.ip_dest        = dest;
    hdr.dest_mac_first = mac;
    hdr.igmp_type      = itype;
    hdr.igmp_group     = igrp;
    hdr.record_kind    = rkind;
    hdr.record_group   = rgrp;
    return hdr;
  endfunction

  // The pool always holds address zero and the all-ones address.
  task automatic new_pool(input int count);
    grp_pool.delete();
    grp_pool.push_back(32'h0000_0000);
    grp_pool.push_back(32'hFFFF_FFFF);
    for (int i = 2; i < count; i++) grp_pool.push_back($urandom);
  endtask

  // Random header. Most are well-formed membership messages from the LAN
  // port or multicast lookups from the WAN port; a slice of the membership
  // messages gets one field spoiled, and the rest is pure noise.
  function automatic in_item_t rand_hdr(input int upd_pct, input int join_pct);
    in_item_t    hdr;
    int          pick;
    logic [31:0] grp;
    hdr.ingress_port   = 4'($urandom_range(15));
    hdr.ether_type     = 16'($urandom);
    hdr.ip_protocol    = 8'($urandom);
    hdr.ip_dest        = $urandom;
    hdr.dest_mac_first = 8'($urandom);
    hdr.igmp_type      = 8'($urandom);
    hdr.igmp_group     = $urandom;
    hdr.record_kind    = 8'($urandom);
    hdr.record_group   = $urandom;
    grp  = grp_pool[$urandom_range(grp_pool.size() - 1)];
    pick = $urandom_range(99);
    if (pick < upd_pct + 15) begin
      hdr.ingress_port = lan_sel;
      hdr.ether_type   = ETHER_IPV4;
      hdr.ip_protocol  = PROTO_IGMP;
      if ($urandom_range(99) < join_pct) begin
        if ($urandom_range(1) == 0) begin
          hdr.igmp_type  = IGMP_V2_REPORT;
          hdr.igmp_group = grp;
        end else begin
          hdr.igmp_type    = IGMP_V3_REPORT;
          hdr.record_kind  = REC_TO_EXCLUDE;
          hdr.record_group = grp;
        end
      end else begin
        if ($urandom_range(1) == 0) begin
          hdr.igmp_type  = IGMP_V2_LEAVE;
          hdr.igmp_group = grp;
        end else begin
          hdr.igmp_type    = IGMP_V3_REPORT;
          hdr.record_kind  = REC_TO_INCLUDE;
          hdr.record_group = grp;
        end
      end
      // Makes the same item a lookup too when the LAN and WAN ports match.
      if ($urandom_range(1) == 0) begin
        hdr.dest_mac_first = MAC_MCAST;
        hdr.ip_dest        = grp;
      end
      if (pick >= upd_pct) begin
        case ($urandom_range(4))
          0:       hdr.ingress_port = 4'($urandom_range(15));
          1:       hdr.ether_type   = 16'($urandom);
          2:       hdr.ip_protocol  = 8'($urandom);
          3:       hdr.igmp_type    = 8'($urandom);
          default: hdr.record_kind  = 8'($urandom);
        endcase
      end
    end else if (pick < upd_pct + 45) begin
      hdr.ingress_port = wan_sel;
      if ($urandom_range(9) != 0) hdr.dest_mac_first = MAC_MCAST;
      if ($urandom_range(4) != 0) hdr.ip_dest = grp;
    end
    return hdr;
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  task automatic test_reset_defaults();
    cfg_readback(REG_ENABLE);
    cfg_readback(REG_LAN_PORT);
    cfg_readback(REG_WAN_PORT);
  endtask

  // With snooping off a report must not reach the table and a lookup must
  // not forward; the first lookup of the next test confirms the table.
  task automatic test_disabled();
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT, 32'h0, 8'h00, '0));
    send_hdr(mk_hdr(4'd1, ETHER_IPV4, PROTO_IGMP, 32'h0, MAC_MCAST, 8'h00, '0, 8'h00, '0));
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V3_REPORT, '0,
                    REC_TO_EXCLUDE, 32'hFFFF_FFFF));
  endtask

  task automatic test_table_updates();
    configure(1'b1, 4'd0, 4'd1);
    // The table must still be empty after the disabled reports.
    send_hdr(mk_hdr(4'd1, ETHER_IPV4, 8'h11, 32'h0, MAC_MCAST, 8'h00, '0, 8'h00, '0));
    // Group zero is an ordinary group; a second report of it changes nothing.
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT, 32'h0, 8'h00, '0));
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT, 32'h0, 8'h00, '0));
    // Lookups ignore the Ethernet type and protocol, but need the MAC byte.
    send_hdr(mk_hdr(4'd1, 16'h0000, 8'h00, 32'h0, MAC_MCAST, 8'h00, '0, 8'h00, '0));
    send_hdr(mk_hdr(4'd1, ETHER_IPV4, PROTO_IGMP, 32'h0, 8'h00, 8'h00, '0, 8'h00, '0));
    send_hdr(mk_hdr(4'd1, ETHER_IPV4, PROTO_IGMP, 32'hFFFF_FFFF, MAC_MCAST, 8'h00, '0,
                    8'h00, '0));
    // A v3 report joins through its first record and leaves with to-include.
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V3_REPORT, '0,
                    REC_TO_EXCLUDE, 32'hFFFF_FFFF));
    send_hdr(mk_hdr(4'd1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, MAC_MCAST, 8'hFF, 32'hFFFF_FFFF,
                    8'hFF, 32'hFFFF_FFFF));
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V3_REPORT, '0,
                    REC_TO_INCLUDE, 32'hFFFF_FFFF));
    // Leaving a group that is not subscribed changes nothing.
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V3_REPORT, '0,
                    REC_TO_INCLUDE, 32'hFFFF_FFFF));
    // Unknown record kinds and message types are ignored; a v2 leave then removes group zero.
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V3_REPORT, '0, 8'hFF, 32'h0));
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, 8'h11, 32'h0, REC_TO_INCLUDE, 32'h0));
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_LEAVE, 32'h0, 8'h00, '0));
    send_hdr(mk_hdr(4'd1, ETHER_IPV4, PROTO_IGMP, 32'h0, MAC_MCAST, 8'h00, '0, 8'h00, '0));
    // Not IGMP, or not from the LAN port: no table change.
    send_hdr(mk_hdr(4'd0, 16'h86DD, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT, 32'h5, 8'h00, '0));
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, 8'h11, '0, 8'h00, IGMP_V2_REPORT, 32'h5, 8'h00, '0));
    send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT, 32'h5, 8'h00, '0));
  endtask

  // LAN and WAN on the same port: the join is visible to the lookup of the
  // very same item, and a leave hides it again.
  task automatic test_shared_port();
    configure(1'b1, 4'd15, 4'd15);
    send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, 32'hE000_0001, MAC_MCAST, IGMP_V2_REPORT,
                    32'hE000_0001, 8'h00, '0));
    send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, 32'hE000_0001, MAC_MCAST, IGMP_V2_LEAVE,
                    32'hE000_0001, 8'h00, '0));
  endtask

  // Fills the table past its depth so the last joins are dropped, checks
  // that a freed slot is reused, then empties the table again.
  task automatic test_table_full();
    logic [31:0] base;
    configure(1'b1, 4'd15, 4'd0);
    base = $urandom;
    for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
      if (i % 2 == 0) begin
        send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT, base + i,
                        8'h00, '0));
      end else begin
        send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V3_REPORT, '0,
                        REC_TO_EXCLUDE, base + i));
      end
    end
    // A group already present is not an add, so nothing is dropped.
    send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT, base, 8'h00, '0));
    send_hdr(mk_hdr(4'd0, ETHER_IPV4, PROTO_IGMP, base + 5, MAC_MCAST, 8'h00, '0, 8'h00, '0));
    send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_LEAVE, base + 3,
                    8'h00, '0));
    send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_REPORT,
                    base + TABLE_DEPTH + 1, 8'h00, '0));
    for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
      if (i % 2 == 0) begin
        send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V2_LEAVE, base + i,
                        8'h00, '0));
      end else begin
        send_hdr(mk_hdr(4'd15, ETHER_IPV4, PROTO_IGMP, '0, 8'h00, IGMP_V3_REPORT, '0,
                        REC_TO_INCLUDE, base + i));
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering quick items, so
  // the block's output register and work slot fill and in_ready drops. The
  // sender then pauses until every result is home before going on.
  task automatic test_backpressure();
    in_item_t hdr;
    configure(1'b1, 4'd0, 4'd1);
    new_pool(16);
    hold_req <= ~hold_req;
    for (int i = 0; i < 16; i++) begin
      hdr = rand_hdr(40, 50);
      hdr.ingress_port = 4'd9;
      send_hdr(hdr);
    end
    settle();
    for (int i = 0; i < 16; i++) send_hdr(rand_hdr(40, 50));
  endtask

  // Random phases, each under its own register setting. One phase runs with
  // no idling at all; one joins heavily from a large pool so the table fills
  // and drops joins, and the next keeps that pool and mostly leaves.
  task automatic test_random_phases();
    logic       en;
    logic [3:0] lan;
    logic [3:0] wan;
    int         pool_n;
    int         upd;
    int         joins;
    int         count;
    for (int ph = 0; ph < 7; ph++) begin
      en = 1'b1;
      lan = 4'($urandom_range(15));
      wan = 4'($urandom_range(15));
      pool_n = 32;
      upd = 40;
      joins = 50;
      count = 150;
      case (ph)
        0: begin lan = 4'd0;  wan = 4'd1;  pool_n = 24; count = 170; end
        1: begin lan = 4'd15; wan = 4'd0;  pool_n = 48; end
        2: begin lan = 4'd7;  wan = 4'd7;  pool_n = 16; end
        3: begin en = 1'b0;   pool_n = 16; count = 100; end
        4: begin lan = 4'd15; wan = 4'd15; pool_n = 8; upd = 45; end
        5: begin pool_n = 200; upd = 70; joins = 85; count = 260; end
        6: begin pool_n = 0; upd = 55; joins = 20; end
        default: ;
      endcase
      configure(en, lan, wan);
      if (pool_n > 0) new_pool(pool_n);
      quiet <= (ph == 1);
      for (int i = 0; i < count; i++) send_hdr(rand_hdr(upd, joins));
    end
    quiet <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence: one reset, then the tests in turn, then the verdict.
  // ---------------------------------------------------------------------
  initial begin
    foreach (grp_live[i]) grp_live[i] = 1'b0;
    foreach (grp_addr[i]) grp_addr[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_disabled();
    test_table_updates();
    test_shared_port();
    test_table_full();
    test_backpressure();
    test_random_phases();

    // Every item yields a result, so once nothing is due any further result
    // would be a stray one; give the block a full worst-case item to show it.
    settle();
    repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
    if (verdicts_due.size() != 0) note_fail("results still outstanding at the end");

    if (fail_count == 0) begin
      $display("** igmp_snooping_group_filter: PASSED **");
    end else begin
      $display("** igmp_snooping_group_filter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
design/igsf_pkg.sv
design/igsf_ctrl.sv
design/igsf_dpath.sv
design/igmp_snooping_group_filter.sv
design/igsf_checker.sv
bench/tb.sv
